### hdl/lkc_pkg.sv
// Shared constants and types for the LRU key cache.
package lkc_pkg;

   localparam int CAPACITY = 16;
   localparam int KEY_BITS = 32;
   localparam int OUT_KEY_BITS = 32;
   localparam int CNT_WIDTH = 32;
   localparam int POS_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OCC_BITS = $clog2(CAPACITY + 1);

   typedef logic [KEY_BITS-1:0] key_type;
   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [OCC_BITS-1:0] occ_type;

   // Outcome of one lookup, as seen by the pipeline around the table.
   typedef struct packed {
      logic    hit;
      logic    evicted_valid;
      key_type evicted_key;
   } lookup_type;

endpackage

### hdl/lkc_table.sv
// Recency-ordered key list with parallel match and move-to-front update.
module lkc_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               upd_en,
   input  lkc_pkg::key_type   look_key,
   output lkc_pkg::lookup_type res,
   output lkc_pkg::occ_type   occupancy
);

   // Position 0 holds the most recent key; positions at or above the
   // count hold stale data that is never matched.
   lkc_pkg::key_type key_list_ff [lkc_pkg::CAPACITY];
   lkc_pkg::key_type key_list_in [lkc_pkg::CAPACITY];
   lkc_pkg::occ_type count_ff;
   lkc_pkg::occ_type count_in;

   logic [lkc_pkg::CAPACITY-1:0] match;
   lkc_pkg::pos_type found_pos;
   lkc_pkg::pos_type shift_pos;
   logic             full;

   assign full = (count_ff == lkc_pkg::OCC_BITS'(lkc_pkg::CAPACITY));

   always_comb begin
      for (int i = 0; i < lkc_pkg::CAPACITY; i++) begin
         match[i] = (lkc_pkg::OCC_BITS'(i) < count_ff) && (key_list_ff[i] == look_key);
      end
   end

   always_comb begin
      found_pos = '0;
      for (int i = lkc_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (match[i]) begin
            found_pos = lkc_pkg::POS_BITS'(i);
         end
      end
   end

   always_comb begin
      res.hit           = |match;
      res.evicted_valid = !res.hit && full;
      res.evicted_key   = res.evicted_valid ? key_list_ff[lkc_pkg::CAPACITY-1] : '0;
      if (res.hit) begin
         shift_pos = found_pos;
      end else if (full) begin
         shift_pos = lkc_pkg::POS_BITS'(lkc_pkg::CAPACITY - 1);
      end else begin
         shift_pos = count_ff[lkc_pkg::POS_BITS-1:0];
      end
   end

   // Everything up to the chosen position slides down by one and the
   // accessed key lands in front.
   always_comb begin
      for (int i = 0; i < lkc_pkg::CAPACITY; i++) begin
         if (i == 0) begin
            key_list_in[i] = look_key;
         end else if (lkc_pkg::POS_BITS'(i) <= shift_pos) begin
            key_list_in[i] = key_list_ff[(i > 0) ? i - 1 : 0];
         end else begin
            key_list_in[i] = key_list_ff[i];
         end
      end
      count_in = (!res.hit && !full) ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (upd_en) begin
         key_list_ff <= key_list_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (upd_en) begin
         count_ff <= count_in;
      end
   end

   assign occupancy = count_ff;

   a_front_is_key: assert property (@(posedge clock) disable iff (reset)
      upd_en |=> key_list_ff[0] == $past(look_key))
      else $error("accessed key is not most recent after update");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      res.evicted_valid |-> (count_ff == lkc_pkg::OCC_BITS'(lkc_pkg::CAPACITY)) && !res.hit)
      else $error("eviction reported without a full table");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (upd_en && !res.hit && !full) |=>
         count_ff == lkc_pkg::OCC_BITS'($past(count_ff) + 1'b1))
      else $error("occupancy did not grow on a miss with room");

endmodule

### hdl/lru_key_cache.sv
// Top level of the fully associative LRU key cache.
// Path: an accepted word is held in the input register, and its lookup result is
// loaded into the result register once that register is free.
// Throughput: one word per cycle unless the result side stalls; the combinational
// match and move-to-front update of the 16-entry recency list sets this rate.
// Reset: synchronous and active high; it empties the table and zeroes both
// counters.
module lru_key_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic        rsp_evicted_valid,
   output logic [31:0] rsp_evicted_key,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [4:0]  rsp_occupancy
);

   // The input register holds one accepted word. The lookup runs between
   // it and the result register; the table state and the counters update
   // at the same edge the result is captured, so the next word sees them.
   logic             s1_valid_ff;
   logic             s1_valid_in;
   lkc_pkg::key_type s1_key_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             hit_ff;
   logic             ev_valid_ff;
   logic [31:0]      ev_key_ff;

   // Running totals; they also serve as the result fields, since they only
   // change when a new result is loaded.
   logic [lkc_pkg::CNT_WIDTH-1:0] hits_ff;
   logic [lkc_pkg::CNT_WIDTH-1:0] hits_in;
   logic [lkc_pkg::CNT_WIDTH-1:0] misses_ff;
   logic [lkc_pkg::CNT_WIDTH-1:0] misses_in;

   logic                out_free;
   logic                accept;
   logic                upd_en;
   lkc_pkg::lookup_type res;
   lkc_pkg::occ_type    occupancy;

   // The result register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign upd_en    = s1_valid_ff && out_free;

   // The input register stays full while its word waits on a stalled result,
   // and it also takes a new word while the result side is stalled but the
   // input register itself is empty.
   assign s1_valid_in  = accept || (s1_valid_ff && !out_free);
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   // Saturating counters: a total stuck at all ones stays there.
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      if (res.hit) begin
         if (hits_ff != '1) begin
            hits_in = hits_ff + 1'b1;
         end
      end else begin
         if (misses_ff != '1) begin
            misses_in = misses_ff + 1'b1;
         end
      end
   end

   lkc_table u_table (
      .clock     (clock),
      .reset     (reset),
      .upd_en    (upd_en),
      .look_key  (s1_key_ff),
      .res       (res),
      .occupancy (occupancy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_en) begin
            hits_ff   <= hits_in;
            misses_ff <= misses_in;
         end
      end
   end

   // Payload registers load without reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_ff <= req_key[lkc_pkg::KEY_BITS-1:0];
      end
      if (upd_en) begin
         hit_ff      <= res.hit;
         ev_valid_ff <= res.evicted_valid;
         ev_key_ff   <= lkc_pkg::OUT_KEY_BITS'(res.evicted_key);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_key   = ev_key_ff;
   assign rsp_hit_total     = hits_ff;
   assign rsp_miss_total    = misses_ff;
   assign rsp_occupancy     = occupancy;

endmodule

### dv/tb_lru_key_cache.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key cache under random valid/stall flow control.
module tb_lru_key_cache;

   // The last words of the run go through with no idling on either side.
   localparam int TAIL_WORDS = 150;
   // Number of random lookup words after the directed opening.
   localparam int RANDOM_WORDS = 880;
   // Allowance for words still in the pipeline, used in the wait at the end of the run.
   localparam int LATENCY = 2;

   // One request word waiting to be driven. When hold_for_drain is set, the
   // driver holds it back until every outstanding result word has come back.
   typedef struct {
      logic [31:0] key;
      bit          hold_for_drain;
   } lookup_word_type;

   // Everything that one result word carries.
   typedef struct {
      logic             hit;
      logic             evicted_valid;
      logic [31:0]      evicted_key;
      logic [31:0]      hit_total;
      logic [31:0]      miss_total;
      lkc_pkg::occ_type occupancy;
   } access_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_key = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic        rsp_evicted_valid;
   logic [31:0] rsp_evicted_key;
   logic [31:0] rsp_hit_total;
   logic [31:0] rsp_miss_total;
   logic [4:0]  rsp_occupancy;

   lru_key_cache dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key           (req_key),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_key   (rsp_evicted_key),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total),
      .rsp_occupancy     (rsp_occupancy)
   );

   always #5 clock = ~clock;

   // Lookup words still to be driven, and the outcomes that the cache owes us,
   // oldest first.
   lookup_word_type    pending_words[$];
   access_outcome_type owed_outcomes[$];

   // Our own copy of the table. Recency positions 0 .. resident-1 hold the
   // resident slots with the most recent one first; the rest are free slots.
   // Slot keys are only ever read for slots marked in use.
   lkc_pkg::key_type slot_key[lkc_pkg::CAPACITY];
   bit               slot_in_use[lkc_pkg::CAPACITY];
   lkc_pkg::pos_type recency[lkc_pkg::CAPACITY];
   int unsigned      resident;
   logic [lkc_pkg::CNT_WIDTH-1:0] hits_so_far;
   logic [lkc_pkg::CNT_WIDTH-1:0] misses_so_far;

   // Flow control state. req_fire records that the word on the request port
   // was taken at the last rising edge, so the driver may move on.
   logic req_fire = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   mode_left = 0;
   bit   calm = 1'b0;
   int   mismatches = 0;

   // Looks one key up in the shadow table, updates recency, residency and the
   // saturating totals, and returns the outcome the cache has to report.
   function automatic access_outcome_type lru_access(logic [31:0] raw_key);
      lkc_pkg::key_type   k;
      int                 found;
      int                 fill;
      lkc_pkg::pos_type   moved;
      access_outcome_type o;
      k = lkc_pkg::key_type'(raw_key);
      found = -1;
      o = '{default: '0};
      for (int p = 0; p < resident; p++)
         if (found < 0 && slot_in_use[recency[p]] && slot_key[recency[p]] == k)
            found = p;
      if (found >= 0) begin
         o.hit = 1'b1;
         if (hits_so_far != '1)
            hits_so_far++;
         fill = found;
      end else begin
         if (misses_so_far != '1)
            misses_so_far++;
         if (resident >= lkc_pkg::CAPACITY) begin
            // Table is full: the least recent slot is reported and reused.
            fill = lkc_pkg::CAPACITY - 1;
            o.evicted_valid = slot_in_use[recency[fill]];
            if (o.evicted_valid)
               o.evicted_key = 32'(slot_key[recency[fill]]);
         end else begin
            // Free room: the first free slot in recency order gets the key.
            fill = resident;
            resident++;
         end
         slot_key[recency[fill]] = k;
         slot_in_use[recency[fill]] = 1'b1;
      end
      // Move to front. A hit on the most recent key leaves the order as it is.
      moved = recency[fill];
      for (int i = fill; i > 0; i--)
         recency[i] = recency[i - 1];
      recency[0] = moved;
      o.hit_total = 32'(hits_so_far);
      o.miss_total = 32'(misses_so_far);
      o.occupancy = lkc_pkg::occ_type'(resident);
      return o;
   endfunction

   task automatic queue_word(logic [31:0] key, bit hold_for_drain);
      lookup_word_type w;
      w.key = key;
      w.hold_for_drain = hold_for_drain;
      pending_words.insert(pending_words.size(), w);
   endtask

   // Monitor: at each rising edge, an accepted request word is run through the
   // shadow table, and an accepted result word is checked against the oldest
   // outcome still owed.
   always @(posedge clock) begin
      access_outcome_type want;
      access_outcome_type got;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            owed_outcomes.insert(owed_outcomes.size(), lru_access(req_key));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_hit, rsp_evicted_valid, rsp_evicted_key,
                    rsp_hit_total, rsp_miss_total, rsp_occupancy};
            if (owed_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result word with none expected: hit=%0b evicted=%0b/%h",
                           $realtime, got.hit, got.evicted_valid, got.evicted_key);
            end else begin
               want = owed_outcomes[0];
               owed_outcomes.delete(0);
               if (got.hit !== want.hit || got.evicted_valid !== want.evicted_valid ||
                   got.evicted_key !== want.evicted_key ||
                   got.hit_total !== want.hit_total ||
                   got.miss_total !== want.miss_total ||
                   got.occupancy !== want.occupancy) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected hit=%0b evicted=%0b/%h hits=%0d misses=%0d occ=%0d",
                              want.hit, want.evicted_valid, want.evicted_key,
                              want.hit_total, want.miss_total, want.occupancy);
                     $display("   actual   hit=%0b evicted=%0b/%h hits=%0d misses=%0d occ=%0d",
                              got.hit, got.evicted_valid, got.evicted_key,
                              got.hit_total, got.miss_total, got.occupancy);
                  end
               end
            end
         end
      end
   end

   // Driver: at each falling edge, decide the next request word and the
   // result-side stall. Idling comes in random bursts, and whole stretches of
   // the run are calm with no idling at all. Each port gets a single
   // nonblocking assignment per edge.
   always @(negedge clock) begin
      lookup_word_type nxt;
      logic            next_valid;
      logic [31:0]     next_key;
      logic            next_stall;
      bit              idle_ok;
      next_valid = req_valid;
      next_key = req_key;
      next_stall = 1'b0;
      if (mode_left == 0) begin
         calm = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(64, 256);
      end else begin
         mode_left--;
      end
      idle_ok = !calm && pending_words.size() >= TAIL_WORDS;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         // A word that has not been taken yet stays on the port unchanged.
         if (!req_valid || req_fire) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_words.size() > 0 &&
                         !(pending_words[0].hold_for_drain && owed_outcomes.size() > 0)) begin
               nxt = pending_words[0];
               pending_words.delete(0);
               next_valid = 1'b1;
               next_key = nxt.key;
               if (idle_ok && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 11);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (idle_ok && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            next_stall = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_key <= next_key;
      rsp_stall <= next_stall;
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [31:0] pool[$];
      logic [31:0] k;
      logic [31:0] last_key;
      int          produced;
      int          phase_len;
      int          pool_size;

      // Shadow table after reset: empty, recency list holds the slots in order.
      for (int i = 0; i < lkc_pkg::CAPACITY; i++) begin
         slot_in_use[i] = 1'b0;
         recency[i] = lkc_pkg::pos_type'(i);
      end
      resident = 0;
      hits_so_far = '0;
      misses_so_far = '0;

      // Directed opening: both key extremes, a hit on the most recent key, a
      // hit further down the list, filling the free slots in turn, evictions
      // from a full table, and a key coming back after it was evicted.
      queue_word(32'h0000_0000, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h0000_0000, 1'b0);
      for (int i = 1; i <= lkc_pkg::CAPACITY - 2; i++)
         queue_word((32'h1 << (2 * i)) ^ 32'h5A00_0000, 1'b0);
      queue_word(32'hAAAA_AAAA, 1'b0);
      queue_word(32'h5555_5555, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b0);
      queue_word(32'h5555_5555, 1'b0);
      queue_word(32'h5555_5555, 1'b0);
      last_key = 32'h5555_5555;

      // Random part in phases. Each phase draws keys mostly from a working set
      // whose size ranges from well inside the capacity (mostly hits) to well
      // beyond it (steady eviction). Near-miss keys differ from a set member in
      // one bit. Some phases start only after everything owed has come back.
      produced = 0;
      while (produced < RANDOM_WORDS) begin
         pool.delete();
         pool_size = $urandom_range(2, 2 * lkc_pkg::CAPACITY + 8);
         repeat (pool_size) begin
            case ($urandom_range(0, 7))
               0: pool.insert(pool.size(), 32'h0000_0000);
               1: pool.insert(pool.size(), 32'hFFFF_FFFF);
               2: pool.insert(pool.size(), pool.size() > 0 ?
                              pool[pool.size() - 1] ^ (32'h1 << $urandom_range(0, 31)) :
                              $urandom());
               default: pool.insert(pool.size(), $urandom());
            endcase
         end
         phase_len = $urandom_range(40, 160);
         for (int n = 0; n < phase_len && produced < RANDOM_WORDS; n++) begin
            case ($urandom_range(0, 9))
               0: k = $urandom();
               1: k = last_key;
               default: k = pool[$urandom_range(0, pool.size() - 1)];
            endcase
            queue_word(k, n == 0 && (produced == 0 || $urandom_range(0, 2) == 0));
            last_key = k;
            produced++;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every word has been sent and every outcome has come back,
      // then give the pipeline a little longer to show any stray result.
      do
         @(posedge clock);
      while (pending_words.size() > 0 || req_valid || owed_outcomes.size() > 0);
      repeat (LATENCY + 4) @(posedge clock);

      if (mismatches == 0 && owed_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(2_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/lkc_pkg.sv
hdl/lkc_table.sv
hdl/lru_key_cache.sv
dv/tb_lru_key_cache.sv
